// ===== rtl/core/lru_key_stack_assert.svh =====
// Assertion macros used by the LRU key stack top level.
`ifndef LRU_KEY_STACK_ASSERT_SVH
`define LRU_KEY_STACK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lks_pkg.sv =====
// Package: shared constants and types of the LRU key stack.
`timescale 1ns / 1ps
package lks_pkg;

    localparam int LKS_MAX_ENTRIES = 8;
    localparam int LKS_KEY_W       = 32;
    localparam int LKS_CAP_W       = 4;
    localparam int LKS_RANK_OUT_W  = 3;
    localparam int LKS_OCC_OUT_W   = 4;
    localparam logic [LKS_CAP_W-1:0] LKS_CAP_RESET = 4'd5;

    localparam int LKS_APB_DATA_W = 32;
    localparam int LKS_APB_ADDR_W = 2;

    // Register index of the capacity limit.
    localparam logic [LKS_APB_ADDR_W-1:0] LKS_REG_CAPACITY = 2'd0;

    // Per-cell control, driven by the top level.
    typedef struct packed {
        logic                 shift;
        logic [LKS_KEY_W-1:0] probe;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/lks_cell.sv =====
// One rank of the LRU key stack: key register, comparator, shift from neighbor.
`timescale 1ns / 1ps
module lks_cell
    import lks_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [LKS_KEY_W-1:0] i_prev_key,
    output logic [LKS_KEY_W-1:0] o_key,
    output logic                 o_match
);

    logic [LKS_KEY_W-1:0] r_key;

    // Take the neighbor's key when the stack shifts through this rank.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key   = r_key;
    assign o_match = (r_key == i_ctrl.probe);

endmodule

// ===== rtl/core/lks_apb_regs.sv =====
// APB register file of the LRU key stack: the capacity limit.
`timescale 1ns / 1ps
module lks_apb_regs
    import lks_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [LKS_APB_ADDR_W-1:0] paddr,
    input  logic [LKS_APB_DATA_W-1:0] pwdata,
    output logic [LKS_APB_DATA_W-1:0] prdata,
    output logic                      pready,
    output logic [LKS_CAP_W-1:0]      o_capacity
);

    logic [LKS_CAP_W-1:0] r_cap;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= LKS_CAP_RESET;
        end else if (wr_en && ((paddr >> 2) == LKS_REG_CAPACITY)) begin
            r_cap <= pwdata[LKS_CAP_W-1:0];
        end
    end

    assign prdata     = {{(LKS_APB_DATA_W-LKS_CAP_W){1'b0}}, r_cap};
    assign o_capacity = r_cap;

endmodule

// ===== rtl/core/lru_key_stack.sv =====
// Top level of the LRU key stack: sequencer, cell row and result register.
//
// Fully associative LRU stack of 32-bit keys kept in a row of MAX_ENTRIES
// cells, rank 0 most recent. Each accepted access passes through the steps
// accept, search (every cell compares its key in parallel and the match
// vector is registered), update (the row shifts down by one rank up to the
// hit rank or the fill level and the key lands in rank 0, while the result
// is written to the output register). A new access is taken once the
// sequencer is back in idle, so no new access is taken before the last
// one is done; the update waits only while an earlier result is still not
// transferred. A hit reports its rank; a miss with the store at the
// capacity limit evicts and reports the least recent key. The limit is
// register 0 on the APB port (reset 5, 0 acts as 1, above MAX_ENTRIES acts
// as MAX_ENTRIES) and is to be changed only while the block is idle. The
// store starts empty; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "lru_key_stack_assert.svh"
module lru_key_stack
    import lks_pkg::*;
#(
    parameter int MAX_ENTRIES = LKS_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // access channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LKS_KEY_W-1:0]      i_access_key,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_hit,
    output logic [LKS_RANK_OUT_W-1:0] o_hit_rank,
    output logic                      o_evicted,
    output logic [LKS_KEY_W-1:0]      o_evicted_key,
    output logic [LKS_OCC_OUT_W-1:0]  o_occupancy,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [LKS_APB_ADDR_W-1:0] paddr,
    input  logic [LKS_APB_DATA_W-1:0] pwdata,
    output logic [LKS_APB_DATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RW = $clog2(MAX_ENTRIES);
    localparam int LW = (CW > LKS_CAP_W) ? CW : LKS_CAP_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [LKS_KEY_W-1:0] r_key;
    logic [CW-1:0]        r_count, n_count;
    logic [MAX_ENTRIES-1:0] r_match;
    logic [LKS_KEY_W-1:0] r_tail_key, n_tail_key;

    logic [LKS_CAP_W-1:0] cap;
    logic                 in_xfer, out_free, do_update;

    t_cell_ctrl           cell_ctrl [MAX_ENTRIES];
    logic [LKS_KEY_W-1:0] cell_key  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;

    logic [MAX_ENTRIES-1:0] first_hit;
    logic                 hit;
    logic [RW-1:0]        rank;
    logic [LW-1:0]        eff_limit, cap_ext, count_ext;
    logic                 evict;
    logic [CW-1:0]        count_kept, shift_limit;

    // result register
    logic                 r_out_valid;
    logic                 r_hit, r_evicted;
    logic [LKS_RANK_OUT_W-1:0] r_rank_out;
    logic [LKS_KEY_W-1:0] r_ev_key;
    logic [LKS_OCC_OUT_W-1:0]  r_occ_out;
    logic [RW+LKS_RANK_OUT_W-1:0] rank_wide;
    logic [CW+LKS_OCC_OUT_W-1:0]  occ_wide;

    lks_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (cap)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign do_update  = (r_state == ST_UPDATE) && out_free;

    // Sequencer: hold in update until the result register is free.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_SEARCH;
            ST_SEARCH: n_state = ST_UPDATE;
            ST_UPDATE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key <= i_access_key;
        end
    end

    // Row of cells; rank 0 takes the access key, each other rank its upper neighbor.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [LKS_KEY_W-1:0] prev_key;
        if (g == 0) begin : g_head
            assign prev_key = r_key;
            assign cell_ctrl[g].shift = do_update;
        end else begin : g_body
            assign prev_key = cell_key[g-1];
            assign cell_ctrl[g].shift = do_update && (CW'(g) <= shift_limit);
        end
        assign cell_ctrl[g].probe = r_key;

        lks_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl[g]),
            .i_prev_key (prev_key),
            .o_key      (cell_key[g]),
            .o_match    (cell_match[g])
        );
    end

    // Search: keep matches of filled ranks only, pick out the least recent key.
    always_comb begin
        n_tail_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CW'(i + 1) == r_count) begin
                n_tail_key = n_tail_key | cell_key[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEARCH) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_match[i] <= cell_match[i] && (CW'(i) < r_count);
            end
            r_tail_key <= n_tail_key;
        end
    end

    // Update: encode the hit rank, decide eviction and the shift depth.
    assign first_hit = r_match & (~r_match + MAX_ENTRIES'(1));
    assign hit       = |r_match;

    always_comb begin
        rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (first_hit[i]) begin
                rank = rank | RW'(i);
            end
        end
    end

    assign cap_ext   = LW'(cap);
    assign count_ext = LW'(r_count);

    always_comb begin
        if (cap_ext == '0) begin
            eff_limit = LW'(1);
        end else if (cap_ext > LW'(MAX_ENTRIES)) begin
            eff_limit = LW'(MAX_ENTRIES);
        end else begin
            eff_limit = cap_ext;
        end
    end

    assign evict       = !hit && (count_ext >= eff_limit) && (r_count != '0);
    assign count_kept  = evict ? (r_count - CW'(1)) : r_count;
    assign shift_limit = hit ? CW'(rank) : count_kept;
    assign n_count     = hit ? r_count : (count_kept + CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_update) begin
            r_count <= n_count;
        end
    end

    // Result register: fill on update, drop after transfer.
    assign rank_wide = {{LKS_RANK_OUT_W{1'b0}}, (hit ? rank : RW'(0))};
    assign occ_wide  = {{LKS_OCC_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_hit      <= hit;
            r_rank_out <= rank_wide[LKS_RANK_OUT_W-1:0];
            r_evicted  <= evict;
            r_ev_key   <= evict ? r_tail_key : '0;
            r_occ_out  <= occ_wide[LKS_OCC_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_hit_rank    = r_rank_out;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_ev_key;
    assign o_occupancy   = r_occ_out;

    // Keys in the stack are unique, so at most one filled rank can match.
    `LKS_ASSERT_NOW(a_match_unique, i_clk, i_rst_n, r_state == ST_UPDATE, $onehot0(r_match), "more than one rank matched")
    // Fill level never passes the number of cells.
    `LKS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ENTRIES), "fill level above store size")
    // An accepted access always goes to the search cycle.
    `LKS_ASSERT_NEXT(a_accept_search, i_clk, i_rst_n, in_xfer, r_state == ST_SEARCH, "accept did not start a search")
    // A hit leaves the fill level unchanged and never evicts.
    `LKS_ASSERT_NEXT(a_hit_keeps_count, i_clk, i_rst_n, do_update && hit, (r_count == $past(r_count)) && !r_evicted, "hit changed the fill level")
    // A hit rank always lies inside the filled part of the stack.
    `LKS_ASSERT_NOW(a_rank_filled, i_clk, i_rst_n, do_update && hit, CW'(rank) < r_count, "hit outside filled ranks")

endmodule
